// ===== sv/clnw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the character LCD nibble writer.
// No dependencies; imported by the top level, front end, job queue, back end and testbench.
package clnw_pkg;

    // Input opcodes
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_CHAR = 2'd1;
    localparam logic [1:0] OP_CMD  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] LINE_TWO_CMD     = 8'hC0;
    localparam logic [7:0] NEWLINE_CODE     = 8'h0A;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;
    localparam logic [5:0] LINE_LENGTH_INIT = 6'd16;

    localparam int JOB_FIFO_DEPTH = 4;

    // Strobe sequencer step counter
    localparam int         STEP_W    = 4;
    localparam logic [3:0] INIT_LAST = 4'd13;
    localparam logic [3:0] BYTE_LAST = 4'd1;
    localparam logic [3:0] WRAP_LAST = 4'd3;

    typedef enum logic [1:0] {
        JOB_INIT = 2'd0,
        JOB_BYTE = 2'd1,
        JOB_WRAP = 2'd2
    } t_job_kind;

    // One queued job: what the back end has to strobe out
    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] value;
    } t_job;

    typedef struct packed {
        logic [3:0] nibble;
        logic [2:0] wait_ms;
    } t_init_strobe;

    // Wake nibbles, then 0x28, 0x08, 0x01, 0x06, 0x0F as high/low pairs
    function automatic t_init_strobe init_strobe(input logic [STEP_W-1:0] step);
        t_init_strobe s;
        case (step)
            4'd0:    s = '{nibble: 4'h3, wait_ms: 3'd5};
            4'd1:    s = '{nibble: 4'h3, wait_ms: 3'd1};
            4'd2:    s = '{nibble: 4'h3, wait_ms: 3'd0};
            4'd3:    s = '{nibble: 4'h2, wait_ms: 3'd3};
            4'd4:    s = '{nibble: 4'h2, wait_ms: 3'd0};
            4'd5:    s = '{nibble: 4'h8, wait_ms: 3'd0};
            4'd6:    s = '{nibble: 4'h0, wait_ms: 3'd0};
            4'd7:    s = '{nibble: 4'h8, wait_ms: 3'd0};
            4'd8:    s = '{nibble: 4'h0, wait_ms: 3'd0};
            4'd9:    s = '{nibble: 4'h1, wait_ms: 3'd0};
            4'd10:   s = '{nibble: 4'h0, wait_ms: 3'd0};
            4'd11:   s = '{nibble: 4'h6, wait_ms: 3'd0};
            4'd12:   s = '{nibble: 4'h0, wait_ms: 3'd0};
            4'd13:   s = '{nibble: 4'hF, wait_ms: 3'd0};
            default: s = '{nibble: 4'h0, wait_ms: 3'd0};
        endcase
        return s;
    endfunction

endpackage

// ===== sv/char_lcd_nibble_writer.sv =====
`timescale 1ns / 1ps
// Top level of the character LCD nibble writer (4-bit bus strobe generator).
// Depends on clnw_pkg, clnw_front, clnw_job_fifo and clnw_back.
//
// Usage:
//   Input channel (push/full): one item per transfer, opcode 0 runs the
//   display init (14 strobes), opcode 1 prints a character (2 strobes, or
//   4 when it wraps to line two), opcode 2 sends a raw command byte
//   (2 strobes). Opcode 3 is dropped with no strobes.
//   Result channel (empty/pop): one enable strobe per transfer, carrying
//   register select, nibble, post-strobe wait in ms, and a last flag on
//   the final strobe of each item.
//   Config channel (cfg valid/ready): writes the line length; ready is
//   always high. Write it only while the block is idle.
// Entry: an item is written into the job queue at its transfer edge, and
//   its first strobe is loaded from there into the output register when
//   the sequencer is free.
// Throughput: one strobe per cycle while the receiver pops, set by the
//   single strobe sequencer; an item uses 2, 4 or 14 strobes. The front end
//   takes an item every cycle until the queue (FIFO_DEPTH entries) fills.
// Reset: clears the queue, the sequencer, the column count, and restores
//   a line length of 16. When the receiver stalls, the strobe holds on the
//   outputs, the sequencer waits, and the queue backs up into full.
module char_lcd_nibble_writer #(
    parameter int FIFO_DEPTH = clnw_pkg::JOB_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_line_length,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_value,
    input  logic       i_string_start,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_register_select,
    output logic [3:0] o_nibble,
    output logic [2:0] o_wait_ms,
    output logic       o_last
);
    import clnw_pkg::*;

    logic accept;
    logic job_valid;
    t_job front_job;
    logic q_empty;
    t_job q_job;
    logic job_done;

    // Transfer in whenever the queue has room
    assign accept = i_push && !o_full;

    clnw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_line_length (i_cfg_line_length),
        .i_accept          (accept),
        .i_opcode          (i_opcode),
        .i_value           (i_value),
        .i_string_start    (i_string_start),
        .o_job_valid       (job_valid),
        .o_job             (front_job)
    );

    // Hold classified jobs until the sequencer drains them
    clnw_job_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && job_valid),
        .i_job   (front_job),
        .o_full  (o_full),
        .i_rd    (job_done),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    clnw_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_empty       (q_empty),
        .i_job             (q_job),
        .o_job_done        (job_done),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_register_select (o_register_select),
        .o_nibble          (o_nibble),
        .o_wait_ms         (o_wait_ms),
        .o_last            (o_last)
    );

endmodule

// ===== sv/clnw_front.sv =====
`timescale 1ns / 1ps
// Front end: line length register, column counter and job classification.
// Depends on clnw_pkg.
module clnw_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [5:0]       i_cfg_line_length,
    input  logic             i_accept,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_value,
    input  logic             i_string_start,
    output logic             o_job_valid,
    output clnw_pkg::t_job   o_job
);
    import clnw_pkg::*;

    logic [5:0] r_line_length;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] base_count;
    logic [7:0] adv_count;
    logic [7:0] wrap_at;
    logic       is_newline;
    logic       wrap;

    assign o_cfg_ready = 1'b1;

    assign is_newline = (i_value == NEWLINE_CODE);
    assign base_count = i_string_start ? 8'd0 : r_count;
    assign adv_count  = (base_count == COUNT_MAX) ? base_count : base_count + 8'd1;
    assign wrap_at    = {2'b00, r_line_length} + 8'd1;
    assign wrap       = !is_newline && (adv_count == wrap_at);

    always_comb begin
        n_count = r_count;
        if (i_accept && i_opcode == OP_CHAR) begin
            if (wrap && adv_count != COUNT_MAX) begin
                n_count = adv_count + 8'd1;
            end else begin
                n_count = adv_count;
            end
        end
    end

    always_comb begin
        o_job_valid = 1'b1;
        o_job       = '{kind: JOB_BYTE, rs: 1'b0, value: i_value};
        case (i_opcode)
            OP_INIT: begin
                o_job.kind = JOB_INIT;
            end
            OP_CMD: begin
                o_job.kind = JOB_BYTE;
            end
            OP_CHAR: begin
                if (is_newline) begin
                    o_job.value = LINE_TWO_CMD;
                end else if (wrap) begin
                    o_job.kind = JOB_WRAP;
                    o_job.rs   = 1'b1;
                end else begin
                    o_job.rs = 1'b1;
                end
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_INIT;
            r_count       <= 8'd0;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_line_length <= i_cfg_line_length;
            end
        end
    end

endmodule

// ===== sv/clnw_job_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the front end and the strobe sequencer.
// Depends on clnw_pkg.
module clnw_job_fifo #(
    parameter int DEPTH = clnw_pkg::JOB_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  clnw_pkg::t_job   i_job,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output clnw_pkg::t_job   o_job
);
    import clnw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/clnw_back.sv =====
`timescale 1ns / 1ps
// Back end: steps through the strobes of the head job into the output register.
// Depends on clnw_pkg.
module clnw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_empty,
    input  clnw_pkg::t_job   i_job,
    output logic             o_job_done,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_register_select,
    output logic [3:0]       o_nibble,
    output logic [2:0]       o_wait_ms,
    output logic             o_last
);
    import clnw_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              r_rs;
    logic [3:0]        r_nib;
    logic [2:0]        r_wait;
    logic              r_last;

    logic              advance;
    logic              fire;
    logic [STEP_W-1:0] last_step;
    logic              step_last;
    logic              s_rs;
    logic [3:0]        s_nib;
    logic [2:0]        s_wait;
    t_init_strobe      init_s;

    assign advance    = !r_out_valid || i_pop;
    assign fire       = advance && !i_job_empty;
    assign step_last  = (r_step == last_step);
    assign o_job_done = fire && step_last;
    assign init_s     = init_strobe(r_step);

    always_comb begin
        last_step = BYTE_LAST;
        s_rs      = i_job.rs;
        s_wait    = 3'd0;
        s_nib     = r_step[0] ? i_job.value[3:0] : i_job.value[7:4];
        case (i_job.kind)
            JOB_INIT: begin
                last_step = INIT_LAST;
                s_rs      = 1'b0;
                s_nib     = init_s.nibble;
                s_wait    = init_s.wait_ms;
            end
            JOB_BYTE: begin
                last_step = BYTE_LAST;
            end
            JOB_WRAP: begin
                last_step = WRAP_LAST;
                // line-two command first, then the character
                if (!r_step[1]) begin
                    s_rs  = 1'b0;
                    s_nib = r_step[0] ? LINE_TWO_CMD[3:0] : LINE_TWO_CMD[7:4];
                end
            end
            default: begin
                last_step = BYTE_LAST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rs   <= s_rs;
            r_nib  <= s_nib;
            r_wait <= s_wait;
            r_last <= step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_step      <= step_last ? '0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_register_select = r_rs;
    assign o_nibble          = r_nib;
    assign o_wait_ms         = r_wait;
    assign o_last            = r_last;

endmodule

// ===== sv/clnw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the character LCD nibble writer, bound to the top level.
// Depends on char_lcd_nibble_writer.
module clnw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic       o_register_select,
    input logic [3:0] o_nibble,
    input logic [2:0] o_wait_ms,
    input logic       o_last
);

    // Reset leaves no strobe waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("strobe pending after reset");

    // Hold a stalled strobe
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_nibble)
            && $stable(o_register_select) && $stable(o_wait_ms) && $stable(o_last))
        else $error("stalled strobe changed");

    // Waits never exceed the longest wake delay
    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_wait_ms <= 3'd5)
        else $error("wait out of range");

    // Data strobes never carry a wait
    a_data_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_register_select |-> o_wait_ms == 3'd0)
        else $error("data strobe with wait");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_empty           (o_empty),
    .i_pop             (i_pop),
    .o_register_select (o_register_select),
    .o_nibble          (o_nibble),
    .o_wait_ms         (o_wait_ms),
    .o_last            (o_last)
);

// ===== dv/char_lcd_nibble_writer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_writer: random and directed items, strobes
// checked against an in-bench predictor. Depends on clnw_pkg and the block's RTL.
module char_lcd_nibble_writer_test;
    import clnw_pkg::*;

    // Wake sequence and setup commands, first entry in the top bits
    localparam logic [15:0] WAKE_NIBBLES = {4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [11:0] WAKE_WAITS   = {3'd5, 3'd1, 3'd0, 3'd3};
    localparam logic [39:0] SETUP_CMDS   = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0F};

    localparam int SETTLE_CYCLES  = 8;    // quiet cycles before a line length write
    localparam int DRAIN_CYCLES   = 20;   // extra cycles at the end for stray strobes
    localparam int WATCHDOG_LIMIT = 1000; // cycles without any transfer
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [1:0] {
        ACT_ITEM     = 2'd0,
        ACT_LINE_LEN = 2'd1,
        ACT_DRAIN    = 2'd2
    } t_action_kind;

    typedef struct {
        t_action_kind kind;
        logic [1:0]   opcode;
        logic [7:0]   value;
        logic         start;
        logic [5:0]   line_len;
    } t_action;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [2:0] wait_ms;
        logic       last;
    } t_strobe;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_cfg_valid       = 1'b0;
    logic [5:0] i_cfg_line_length = 6'd0;
    logic       i_push            = 1'b0;
    logic [1:0] i_opcode          = OP_INIT;
    logic [7:0] i_value           = 8'd0;
    logic       i_string_start    = 1'b0;
    logic       i_pop             = 1'b0;
    logic       o_cfg_ready;
    logic       o_full;
    logic       o_empty;
    logic       o_register_select;
    logic [3:0] o_nibble;
    logic [2:0] o_wait_ms;
    logic       o_last;

    t_action    lcd_actions[$];   // pending items, line length writes and drain points
    t_strobe    strobe_q[$];      // strobes predicted but not yet popped

    // Predictor state
    logic [5:0] line_len_model;
    logic [7:0] column_model;

    int         mismatches = 0;

    char_lcd_nibble_writer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_line_length (i_cfg_line_length),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_value           (i_value),
        .i_string_start    (i_string_start),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_register_select (o_register_select),
        .o_nibble          (o_nibble),
        .o_wait_ms         (o_wait_ms),
        .o_last            (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: turn one accepted item into its expected strobes
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic rs, logic [7:0] data);
        strobe_q.push_back('{rs: rs, nibble: data[7:4], wait_ms: 3'd0, last: 1'b0});
        strobe_q.push_back('{rs: rs, nibble: data[3:0], wait_ms: 3'd0, last: 1'b0});
    endfunction

    // Saturating column advance
    function automatic void bump_column();
        if (column_model != COUNT_MAX) begin
            column_model = column_model + 8'd1;
        end
    endfunction

    function automatic void predict_strobes(logic [1:0] opcode, logic [7:0] value, logic start);
        int      before_cnt;
        t_strobe tail;
        before_cnt = strobe_q.size();
        case (opcode)
            OP_INIT: begin
                for (int i = 0; i < 4; i++) begin
                    strobe_q.push_back('{rs: 1'b0, nibble: WAKE_NIBBLES[15 - 4*i -: 4],
                                         wait_ms: WAKE_WAITS[11 - 3*i -: 3], last: 1'b0});
                end
                for (int i = 0; i < 5; i++) begin
                    queue_byte(1'b0, SETUP_CMDS[39 - 8*i -: 8]);
                end
            end
            OP_CHAR: begin
                if (start) begin
                    column_model = 8'd0;
                end
                bump_column();
                if (value == NEWLINE_CODE) begin
                    queue_byte(1'b0, LINE_TWO_CMD);
                end else begin
                    // wrap to line two once the count passes the line length
                    if ({1'b0, column_model} == {3'b000, line_len_model} + 9'd1) begin
                        queue_byte(1'b0, LINE_TWO_CMD);
                        bump_column();
                    end
                    queue_byte(1'b1, value);
                end
            end
            OP_CMD: queue_byte(1'b0, value);
            default: ; // unused opcode: dropped, nothing changes
        endcase
        if (strobe_q.size() > before_cnt) begin
            tail = strobe_q.pop_back();
            tail.last = 1'b1;
            strobe_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add_item(logic [1:0] opcode, logic [7:0] value, logic start);
        t_action a;
        a.kind     = ACT_ITEM;
        a.opcode   = opcode;
        a.value    = value;
        a.start    = start;
        a.line_len = 6'd0;
        lcd_actions.push_back(a);
    endfunction

    function automatic void add_control(t_action_kind kind, logic [5:0] line_len);
        t_action a;
        a.kind     = kind;
        a.opcode   = OP_NONE;
        a.value    = 8'd0;
        a.start    = 1'b0;
        a.line_len = line_len;
        lcd_actions.push_back(a);
    endfunction

    // A well-formed string: start flag on the first character only
    function automatic void add_string(int len);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
            add_item(OP_CHAR, ch, i == 0);
        end
    endfunction

    // Mostly strings with random content, the rest commands, inits and noise
    function automatic void add_random_phase(int n_items, logic [5:0] line_len);
        int made;
        int pick;
        int len;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = $urandom_range(1, line_len + 4);
                add_string(len);
                made += len;
            end else if (pick < 78) begin
                add_item(OP_CMD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 84) begin
                add_item(OP_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 89) begin
                add_item(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                // stray character with a random start flag
                add_item(OP_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                add_control(ACT_DRAIN, 6'd0);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: one item transfer per handshake, bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;
    int settle_cnt = 0;

    always @(posedge i_clk) begin
        logic push_nxt;
        logic cfg_nxt;
        if (!i_rst_n) begin
            i_push         <= 1'b0;
            i_cfg_valid    <= 1'b0;
            line_len_model = LINE_LENGTH_INIT;
            column_model   = 8'd0;
            settle_cnt     = 0;
        end else begin
            push_nxt = i_push;
            cfg_nxt  = i_cfg_valid;

            // predict on the edge of the transfer
            if (i_push && !o_full) begin
                predict_strobes(i_opcode, i_value, i_string_start);
                push_nxt = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                line_len_model = i_cfg_line_length;
                cfg_nxt        = 1'b0;
            end

            // count quiet cycles so a dropped item can leave the pipe first
            if (push_nxt || strobe_q.size() != 0) begin
                settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
            end

            if (gap_left != 0) begin
                gap_left--;
            end else if (!push_nxt && !cfg_nxt && lcd_actions.size() != 0) begin
                case (lcd_actions[0].kind)
                    ACT_ITEM: begin
                        i_opcode       <= lcd_actions[0].opcode;
                        i_value        <= lcd_actions[0].value;
                        i_string_start <= lcd_actions[0].start;
                        push_nxt = 1'b1;
                        void'(lcd_actions.pop_front());
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            // new burst; about a quarter run on with no gap at all
                            burst_left = $urandom_range(1, 16);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                    ACT_LINE_LEN: begin
                        // write only once the block has gone idle
                        if (settle_cnt == SETTLE_CYCLES) begin
                            i_cfg_line_length <= lcd_actions[0].line_len;
                            cfg_nxt = 1'b1;
                            void'(lcd_actions.pop_front());
                        end
                    end
                    default: begin
                        // hold the sender until every expected strobe has come
                        if (strobe_q.size() == 0) begin
                            void'(lcd_actions.pop_front());
                        end
                    end
                endcase
            end

            i_push      <= push_nxt;
            i_cfg_valid <= cfg_nxt;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pop strobes on a stall pattern and check each field
    // ------------------------------------------------------------------
    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        end
    endfunction

    int       stall_cycle = 0;
    int       stall_mode  = 0;

    always @(posedge i_clk) begin
        t_strobe want;
        t_strobe got;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                got = '{rs: o_register_select, nibble: o_nibble, wait_ms: o_wait_ms,
                        last: o_last};
                if (strobe_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t ns: strobe with nothing expected, expected none, actual %h",
                                 $time, got);
                    end
                end else begin
                    want = strobe_q.pop_front();
                    check_field("register_select", want.rs, got.rs);
                    check_field("nibble", want.nibble, got.nibble);
                    check_field("wait_ms", want.wait_ms, got.wait_ms);
                    check_field("last", want.last, got.last);
                end
            end

            // switch at random between free flow, coin flips and long stalls
            stall_cycle++;
            if (stall_cycle % 64 == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0:       i_pop <= 1'b1;
                1:       i_pop <= 1'($urandom_range(0, 1));
                default: i_pop <= (stall_cycle % 8 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transfer of any kind is seen for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: directed items, then random phases at several line lengths
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic [5:0] len_pick;

        // Reset line length: init, command extremes, character corners, dropped opcode
        add_item(OP_INIT, 8'h00, 1'b0);
        add_item(OP_CMD, 8'h00, 1'b0);
        add_item(OP_CMD, 8'hFF, 1'b1);
        add_item(OP_CMD, 8'hA5, 1'b0);
        add_item(OP_CHAR, 8'h48, 1'b1);
        add_item(OP_CHAR, 8'h00, 1'b0);
        add_item(OP_CHAR, 8'hFF, 1'b0);
        add_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        add_item(OP_NONE, 8'hFF, 1'b1);
        add_item(OP_NONE, 8'h00, 1'b0);
        add_control(ACT_DRAIN, 6'd0);

        // One character per line: wrap, newline with start, wrap again
        add_control(ACT_LINE_LEN, 6'd1);
        add_item(OP_CHAR, 8'h41, 1'b1);
        add_item(OP_CHAR, 8'h42, 1'b0);
        add_item(OP_CHAR, 8'h43, 1'b0);
        add_item(OP_CHAR, NEWLINE_CODE, 1'b1);
        add_item(OP_CHAR, 8'h44, 1'b0);

        add_control(ACT_LINE_LEN, 6'd0);
        add_random_phase(36, 6'd0);
        add_control(ACT_LINE_LEN, 6'd40);
        add_random_phase(36, 6'd40);
        add_control(ACT_LINE_LEN, 6'd63);
        add_random_phase(36, 6'd63);
        // one long string drives the column count into saturation
        add_string(260);
        add_control(ACT_LINE_LEN, 6'd16);
        add_random_phase(36, 6'd16);
        for (int p = 0; p < 2; p++) begin
            len_pick = 6'($urandom_range(0, 63));
            add_control(ACT_LINE_LEN, len_pick);
            add_random_phase(36, len_pick);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait out the stimulus, then the last strobes, then a short tail
        while (lcd_actions.size() != 0 || i_push || i_cfg_valid) begin
            @(posedge i_clk);
        end
        while (strobe_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (strobe_q.size() != 0) begin
            mismatches++;
            $display("%0t ns: strobes left over, expected 0, actual %0d", $time, strobe_q.size());
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
